### design/sle_pkg.sv
package sle_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_COUNT  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SHOW   = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key_a;
    logic signed [31:0] key_b;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_REPORT,
    S_SHOW
  } state_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic show_shift;
  } cell_ctl_t;

endpackage

### design/sle_cell.sv
module sle_cell (
  input  logic                clk,
  input  sle_pkg::cell_ctl_t  ctl,
  input  logic                open_right,
  input  logic                close_left,
  input  logic                place_here,
  input  logic signed [31:0]  new_key,
  input  logic signed [31:0]  left_key,
  input  logic signed [31:0]  right_key,
  input  logic signed [31:0]  cmp_a,
  input  logic signed [31:0]  cmp_b,
  output logic signed [31:0]  key,
  output logic                hit_a,
  output logic                hit_b
);
  import sle_pkg::*;

  // Each cell compares its key with both command keys; the controller
  // masks hits beyond the fill count.
  assign hit_a = (key == cmp_a);
  assign hit_b = (key == cmp_b);

  always_ff @(posedge clk) begin
    if (place_here) begin
      key <= new_key;
    end else if (ctl.shift_right && open_right) begin
      key <= left_key;
    end else if ((ctl.shift_left && close_left) || ctl.show_shift) begin
      key <= right_key;
    end
  end

endmodule

### design/sequential_list_engine_unit.sv
// Channel  | Ports                      | Handshake
// command  | start, busy, cmd_in        | taken when start is high and busy is low
// result   | res_valid, res             | one-cycle strobe per single result; show words stream, never held off
//
// Single-result commands run search, act and report. The result word is
// registered in act and is on the ports during report, and busy drops as
// report ends, so a new command is only taken once the last is through.
// Show streams one word per cycle out of the front cell while the row
// rotates. Its words are registered from the first show state on, and the
// last one is on the ports during report. The rotation puts every key back
// in place. Codes outside the command set are taken and dropped with no
// result and no busy. The receiver cannot stall, so nothing ever waits on
// the result side. Reset clears the state machine and the fill count; the
// cell keys are left as they are.
module sequential_list_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sle_pkg::in_word_t  cmd_in,
  output logic               busy,
  output logic               res_valid,
  output sle_pkg::out_word_t res
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t state, state_next;
  in_word_t  cur;
  logic [CW-1:0] fill;
  logic [CW-1:0] show_cnt;
  logic [CAPACITY-1:0] hit_a, hit_b, hits_a, hits_b;
  logic found_a, found_b;
  logic [IW-1:0] pos_a, pos_b;
  logic signed [31:0] keys [CAPACITY];
  logic signed [31:0] gap;
  cell_ctl_t ctl;
  logic full;
  logic do_place, do_remove;
  logic [CW-1:0] ins_pos;

  // Registered search results: per-cell hits masked to the occupied cells.
  always_ff @(posedge clk) begin
    if (state == S_SEARCH) begin
      for (int i = 0; i < CAPACITY; i++) begin
        hits_a[i] <= hit_a[i] && (i < int'(fill));
        hits_b[i] <= hit_b[i] && (i < int'(fill));
      end
    end
  end

  // First-hit encode in the act cycle.
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    pos_a   = '0;
    pos_b   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits_a[i]) begin
        found_a = 1'b1;
        pos_a   = IW'(i);
      end
      if (hits_b[i]) begin
        found_b = 1'b1;
        pos_b   = IW'(i);
      end
    end
  end

  assign full = (fill == CW'(CAPACITY));
  assign ins_pos = (cmd_t'(cur.cmd) == CMD_APPEND) ? fill :
                   (found_b ? CW'(pos_b) + CW'(1) : '0);
  assign do_place  = (state == S_ACT) && !full &&
                     (cmd_t'(cur.cmd) == CMD_APPEND || cmd_t'(cur.cmd) == CMD_INSERT);
  assign do_remove = (state == S_ACT) && found_a && cmd_t'(cur.cmd) == CMD_REMOVE;

  always_comb begin
    ctl.shift_right = do_place;
    ctl.shift_left  = do_remove;
    ctl.show_shift  = (state == S_SHOW);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lk, rk;
    logic ord, ocl;
    if (g == 0) begin : g_l
      assign lk = keys[0];
    end else begin : g_l
      assign lk = keys[g-1];
    end
    // Show rotates the whole occupied row; the front key wraps to the tail.
    always_comb begin
      if (ctl.show_shift && (CW'(g) + CW'(1) == fill)) rk = keys[0];
      else if (g == CAPACITY - 1) rk = keys[g];
      else rk = keys[(g + 1) % CAPACITY];
    end
    assign ord = (CW'(g) > ins_pos);
    assign ocl = (IW'(g) >= pos_a);
    sle_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .open_right(ord),
      .close_left(ocl),
      .place_here(do_place && (CW'(g) == ins_pos)),
      .new_key   (cur.key_a),
      .left_key  (lk),
      .right_key (rk),
      .cmp_a     (cur.key_a),
      .cmp_b     (cur.key_b),
      .key       (keys[g]),
      .hit_a     (hit_a[g]),
      .hit_b     (hit_b[g])
    );
  end

  // Distance |pa-pb|-1 with a missing key at position -1.
  always_comb begin
    logic signed [CW:0] pa, pb;
    pa = found_a ? $signed({1'b0, CW'(pos_a)}) : '1;
    pb = found_b ? $signed({1'b0, CW'(pos_b)}) : '1;
    if (pa > pb)      gap = 32'(pa - pb - 1);
    else if (pb > pa) gap = 32'(pb - pa - 1);
    else              gap = -32'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      show_cnt <= '0;
    end else begin
      state <= state_next;
      if (do_place) fill <= fill + CW'(1);
      if (do_remove) fill <= fill - CW'(1);
      if (state == S_ACT) show_cnt <= '0;
      else if (state == S_SHOW) show_cnt <= show_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) cur <= cmd_in;
    if (state == S_ACT) begin
      case (cmd_t'(cur.cmd))
        CMD_APPEND, CMD_INSERT: res <= '{full ? ST_FULL : ST_OK, cur.key_a, 1'b1};
        CMD_COUNT:  res <= '{ST_OK, gap, 1'b1};
        CMD_REMOVE: res <= '{found_a ? ST_OK : ST_NOTFOUND, cur.key_a, 1'b1};
        CMD_SHOW:   res <= '{ST_EMPTY, 32'sd0, 1'b1};
        default:    res <= res;
      endcase
    end else if (state == S_SHOW) begin
      res <= '{ST_OK, keys[0], (show_cnt + CW'(1) == fill)};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (cmd_in.cmd inside {CMD_APPEND, CMD_INSERT, CMD_COUNT,
                                         CMD_REMOVE, CMD_SHOW})) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: state_next = S_ACT;
      S_ACT:    state_next = (cmd_t'(cur.cmd) == CMD_SHOW && fill != '0) ? S_SHOW : S_REPORT;
      S_REPORT: state_next = S_IDLE;
      S_SHOW:   state_next = (show_cnt + CW'(1) == fill) ? S_REPORT : S_SHOW;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= (state == S_ACT && !(cmd_t'(cur.cmd) == CMD_SHOW && fill != '0)) ||
                      (state == S_SHOW);
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

endmodule

### design/sle_checker.sv
module sle_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               res_valid,
  input sle_pkg::out_word_t res
);
  import sle_pkg::*;

  a_idle_no_res: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !res_valid) else $error("result while idle");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> busy) else $error("result without busy");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.last) else $error("error without last");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_EMPTY |-> res.value == 32'sd0) else $error("empty value");

endmodule

bind sequential_list_engine_unit sle_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .res_valid(res_valid), .res(res)
);

### sim/sequential_list_engine_unit_tb.sv
module sequential_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int CAPACITY = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int IN_BITS = $bits(in_word_t);

  logic clk;
  logic rst;
  logic start;
  in_word_t cmd_in;
  logic busy;
  logic res_valid;
  out_word_t res;

  sequential_list_engine_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd_in(cmd_in),
    .busy(busy),
    .res_valid(res_valid),
    .res(res)
  );

  // The predictor keeps its own copy of the key list. Result words are
  // worked out when a command word is accepted and queued here.
  logic signed [31:0] shadow_keys[$];
  out_word_t expected_words[$];
  in_word_t pending_cmds[$];

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  // Acceptance is decided at the rising edge and remembered for the driver.
  logic busy_at_edge;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Position of the first occurrence of a key, -1 when the key is missing.
  function automatic int first_pos(logic signed [31:0] key);
    foreach (shadow_keys[i]) if (shadow_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic out_word_t mk_word(logic [1:0] st, logic signed [31:0] v, logic l);
    out_word_t w;
    w.status = st;
    w.value = v;
    w.last = l;
    return w;
  endfunction

  // Apply one accepted command word to the shadow list and queue the words
  // the block must produce for it. Codes outside the command set do nothing.
  task automatic predict_list_op(in_word_t w);
    int pa, pb, d;
    case (w.cmd)
      CMD_APPEND: begin
        if (shadow_keys.size() >= CAPACITY) begin
          expected_words.push_back(mk_word(ST_FULL, w.key_a, 1'b1));
        end else begin
          shadow_keys.push_back(w.key_a);
          expected_words.push_back(mk_word(ST_OK, w.key_a, 1'b1));
        end
      end
      CMD_INSERT: begin
        if (shadow_keys.size() >= CAPACITY) begin
          expected_words.push_back(mk_word(ST_FULL, w.key_a, 1'b1));
        end else begin
          // An absent anchor gives position -1, so the key goes to the front.
          shadow_keys.insert(first_pos(w.key_b) + 1, w.key_a);
          expected_words.push_back(mk_word(ST_OK, w.key_a, 1'b1));
        end
      end
      CMD_COUNT: begin
        pa = first_pos(w.key_a);
        pb = first_pos(w.key_b);
        if (pa > pb) d = pa - pb - 1;
        else if (pb > pa) d = pb - pa - 1;
        else d = -1;
        expected_words.push_back(mk_word(ST_OK, d, 1'b1));
      end
      CMD_REMOVE: begin
        pa = first_pos(w.key_a);
        if (pa < 0) begin
          expected_words.push_back(mk_word(ST_NOTFOUND, w.key_a, 1'b1));
        end else begin
          shadow_keys.delete(pa);
          expected_words.push_back(mk_word(ST_OK, w.key_a, 1'b1));
        end
      end
      CMD_SHOW: begin
        if (shadow_keys.size() == 0) begin
          expected_words.push_back(mk_word(ST_EMPTY, 32'sd0, 1'b1));
        end else begin
          foreach (shadow_keys[i])
            expected_words.push_back(mk_word(ST_OK, shadow_keys[i],
                                             i == shadow_keys.size() - 1));
        end
      end
      default: ;
    endcase
  endtask

  // Driver: inputs move on the falling edge. A command word stays on the
  // port until a rising edge sees start high with busy low. The sender may
  // idle at random.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // Previous word was taken at the last rising edge; pick the next one.
      drive_next();
    end else if (!start) begin
      drive_next();
    end
  end

  always @(posedge clk) begin
    busy_at_edge <= busy;
  end

  task automatic drive_next();
    in_word_t w;
    if (pending_cmds.size() == 0 || $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      cmd_in <= IN_BITS'({$urandom, $urandom, $urandom});
    end else begin
      w = pending_cmds.pop_front();
      start <= 1'b1;
      cmd_in <= w;
    end
  endtask

  // Monitor: command words are predicted when accepted, result words are
  // checked in order against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_list_op(cmd_in);
        idle_cycles <= 0;
      end else if (res_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (res_valid) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word status=%0d value=%0d last=%0b",
                   $time, res.status, res.value, res.last);
          errors++;
        end else begin
          automatic out_word_t e = expected_words.pop_front();
          if (res.status !== e.status || res.value !== e.value ||
              res.last !== e.last) begin
            $display("%0t: mismatch expected status=%0d value=%0d last=%0b",
                     $time, e.status, e.value, e.last);
            $display("%0t:          actual   status=%0d value=%0d last=%0b",
                     $time, res.status, res.value, res.last);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_word_t mk_cmd(logic [2:0] c, logic signed [31:0] a,
                                      logic signed [31:0] b);
    in_word_t w;
    w.cmd = c;
    w.key_a = a;
    w.key_b = b;
    return w;
  endfunction

  // Keys come mostly from a small pool so that searches hit, with the odd
  // full-range value to toggle every bit.
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(12)) - 6;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int r;
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) c = CMD_APPEND;
      else if (r < 50) c = CMD_INSERT;
      else if (r < 65) c = CMD_COUNT;
      else if (r < 85) c = CMD_REMOVE;
      else if (r < 95) c = CMD_SHOW;
      else c = 3'($urandom_range(7, 5));
      pending_cmds.push_back(mk_cmd(c, pick_key(), pick_key()));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd_in = '0;
    busy_at_edge = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list cases, extremes of the keys, every command and
    // two of the ignored codes.
    send_idle_pct = 20;
    pending_cmds.push_back(mk_cmd(CMD_SHOW, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_REMOVE, 32'sh7fffffff, 0));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, 1, 2));
    pending_cmds.push_back(mk_cmd(CMD_APPEND, 32'sh80000000, 0));
    pending_cmds.push_back(mk_cmd(CMD_APPEND, 32'sh7fffffff, 0));
    pending_cmds.push_back(mk_cmd(CMD_APPEND, -1, 0));
    pending_cmds.push_back(mk_cmd(CMD_INSERT, 5, 32'sh7fffffff));
    pending_cmds.push_back(mk_cmd(CMD_INSERT, 6, 1234));
    pending_cmds.push_back(mk_cmd(CMD_APPEND, 5, 0));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, 6, -1));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, -1, 6));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, 5, 5));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, 77, 78));
    pending_cmds.push_back(mk_cmd(CMD_COUNT, 6, 99));
    pending_cmds.push_back(mk_cmd(3'd5, 1, 1));
    pending_cmds.push_back(mk_cmd(3'd7, 1, 1));
    pending_cmds.push_back(mk_cmd(CMD_SHOW, 0, 0));
    pending_cmds.push_back(mk_cmd(CMD_REMOVE, 5, 0));
    pending_cmds.push_back(mk_cmd(CMD_REMOVE, 32'sh80000000, 0));
    pending_cmds.push_back(mk_cmd(CMD_SHOW, 0, 0));

    // Fill the list to capacity, then both growing commands report full.
    for (int i = 0; i < CAPACITY; i++)
      pending_cmds.push_back(mk_cmd(CMD_APPEND, $urandom, 0));
    pending_cmds.push_back(mk_cmd(CMD_APPEND, 3, 0));
    pending_cmds.push_back(mk_cmd(CMD_INSERT, 4, 3));
    pending_cmds.push_back(mk_cmd(CMD_SHOW, 0, 0));

    // The sender holds off here until every expected word has arrived.
    wait_drained();
    for (int i = 0; i < CAPACITY; i++)
      pending_cmds.push_back(mk_cmd(CMD_REMOVE, shadow_keys[i], 0));
    pending_cmds.push_back(mk_cmd(CMD_SHOW, 0, 0));
    wait_drained();

    add_random(24);
    wait_drained();
    send_idle_pct = 46;
    add_random(22);
    wait_drained();
    send_idle_pct = 0;
    add_random(22);
    wait_drained();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
